### design/dhd_pkg.sv
// Shared constants and helpers for the detector head decoder.
package dhd_pkg;

  // Network head layout.
  localparam int CLASS_COUNT  = 36;
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 512;

  // Values in one anchor: eight corner offsets, objectness, class scores.
  localparam int CORNER_VALUES     = 8;
  localparam int OBJ_POS           = CORNER_VALUES;
  localparam int FIRST_CLASS_POS   = CORNER_VALUES + 1;
  localparam int VALUES_PER_ANCHOR = FIRST_CLASS_POS + CLASS_COUNT;

  // Field widths.
  localparam int PRED_W   = 24;
  localparam int CORNER_W = 32;
  localparam int CONF_W   = 23;
  localparam int LABEL_W  = 6;
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = 2 * PRED_W;

  // Counter widths.
  localparam int POS_W  = $clog2(VALUES_PER_ANCHOR);
  localparam int COL_W  = $clog2(FRAME_WIDTH / 8);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT / 8);
  localparam int LVL_W  = 2;
  localparam int CELL_W = (COL_W > ROW_W) ? COL_W : ROW_W;

  localparam logic [CONF_W-1:0] CONF_MAX        = '1;
  localparam logic [CONF_W-1:0] THRESHOLD_RESET = CONF_W'(2867);

  // Stride levels 8, 16 and 32.
  localparam logic [LVL_W-1:0] LVL_S8  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_S16 = 2'd1;
  localparam logic [LVL_W-1:0] LVL_S32 = 2'd2;

  // Last grid column and row on each level.
  localparam logic [COL_W-1:0] LVL_COL_LAST [3] = '{
    COL_W'(FRAME_WIDTH / 8 - 1), COL_W'(FRAME_WIDTH / 16 - 1), COL_W'(FRAME_WIDTH / 32 - 1)
  };
  localparam logic [ROW_W-1:0] LVL_ROW_LAST [3] = '{
    ROW_W'(FRAME_HEIGHT / 8 - 1), ROW_W'(FRAME_HEIGHT / 16 - 1),
    ROW_W'(FRAME_HEIGHT / 32 - 1)
  };

endpackage

### design/dhd_pred_if.sv
// Input stream of raw prediction words.
interface dhd_pred_if import dhd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PRED_W-1:0] pred_value;
  logic                     frame_start;

  modport source (output valid, pred_value, frame_start, input ready);
  modport sink   (input valid, pred_value, frame_start, output ready);
endinterface

### design/dhd_result_if.sv
// Output stream of decoded anchors.
interface dhd_result_if import dhd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       last_anchor;
  logic signed [CORNER_W-1:0] corner1_x;
  logic signed [CORNER_W-1:0] corner1_y;
  logic signed [CORNER_W-1:0] corner2_x;
  logic signed [CORNER_W-1:0] corner2_y;
  logic signed [CORNER_W-1:0] corner3_x;
  logic signed [CORNER_W-1:0] corner3_y;
  logic signed [CORNER_W-1:0] corner4_x;
  logic signed [CORNER_W-1:0] corner4_y;
  logic        [LABEL_W-1:0]  class_label;
  logic        [CONF_W-1:0]   confidence;

  modport source (
    output valid, found, last_anchor, corner1_x, corner1_y, corner2_x, corner2_y,
           corner3_x, corner3_y, corner4_x, corner4_y, class_label, confidence,
    input  ready
  );
  modport sink (
    input  valid, found, last_anchor, corner1_x, corner1_y, corner2_x, corner2_y,
           corner3_x, corner3_y, corner4_x, corner4_y, class_label, confidence,
    output ready
  );
endinterface

### design/detector_head_decode_top.sv
// Top level of the detector head decoder.
//
// The pred_i channel takes one signed Q12.12 prediction word per cycle. Words
// are grouped into anchors of eight corner offsets, one objectness value and
// one score per class; anchors run over strides 8, 16 and 32 in row-major
// order. A word with frame_start set restarts the walk at anchor (0,0) of
// stride 8. The result_o channel gives one word per anchor, with the four
// corners, the best class above the threshold and its confidence, all zero
// when nothing was found.
// Unless a waiting result stalls pred_i, one word is taken per cycle; each word
// passes the 24 by 24 multiplier and the running compare in the cycle it is
// accepted. Accepting the last word of an anchor loads its result into the
// output register. While a result waits there and the receiver is not ready,
// the result is held and pred_i is not ready either. The threshold is written
// through cfg_we_i and cfg_wdata_i; the user must write it only while idle, the
// block itself does not enforce this. Reset clears all counters, the running
// winner and the output valid, and loads the threshold with 0.7 in Q12.12.
module detector_head_decode_top import dhd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CONF_W-1:0] cfg_wdata_i,
  dhd_pred_if.sink          pred_i,
  dhd_result_if.source      result_o
);

  logic [CONF_W-1:0]          threshold_q;
  logic [POS_W-1:0]           pos_q, pos_d;
  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [LVL_W-1:0]           lvl_q, lvl_d;
  logic signed [CORNER_W-1:0] corner_q [CORNER_VALUES];
  logic signed [PRED_W-1:0]   obj_q;
  logic [CONF_W-1:0]          best_q, best_d;
  logic [LABEL_W-1:0]         label_q, label_d;
  logic                       found_q, found_d;

  logic                       accept;
  logic                       anchor_end;
  logic                       frame_last;
  logic [POS_W-1:0]           pos_cur;
  logic [COL_W-1:0]           col_cur;
  logic [ROW_W-1:0]           row_cur;
  logic [LVL_W-1:0]           lvl_cur;
  logic [CELL_W-1:0]          grid_cell;
  logic signed [CORNER_W-1:0] corner_sum;
  logic signed [CORNER_W-1:0] corner_val;
  logic signed [PROD_W-1:0]   prod;
  logic [CONF_W-1:0]          conf;
  logic [CONF_W-1:0]          best_base;
  logic [LABEL_W-1:0]         label_base;
  logic                       found_base;

  logic                       out_valid_q;

  // A new word is taken unless an undelivered result blocks the output register.
  assign pred_i.ready = !out_valid_q || result_o.ready;
  assign accept       = pred_i.valid && pred_i.ready;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // Frame start drops the partial anchor and the walk position.
  always_comb begin
    pos_cur = pred_i.frame_start ? '0 : pos_q;
    col_cur = pred_i.frame_start ? '0 : col_q;
    row_cur = pred_i.frame_start ? '0 : row_q;
    lvl_cur = pred_i.frame_start ? LVL_S8 : lvl_q;
  end

  // Corner offset plus grid cell, scaled by the stride of the level.
  always_comb begin
    grid_cell  = pos_cur[0] ? CELL_W'(row_cur) : CELL_W'(col_cur);
    corner_sum = CORNER_W'(pred_i.pred_value)
               + (CORNER_W'(grid_cell) <<< FRAC_W);
    case (lvl_cur)
      LVL_S8:  corner_val = corner_sum <<< 3;
      LVL_S16: corner_val = corner_sum <<< 4;
      LVL_S32: corner_val = corner_sum <<< 5;
      default: corner_val = corner_sum <<< 3;
    endcase
  end

  // Class confidence: objectness times score, truncated and saturated.
  always_comb begin
    prod = PROD_W'(obj_q) * PROD_W'(pred_i.pred_value);
    if (prod <= 0) begin
      conf = '0;
    end else if ((prod >>> FRAC_W) > PROD_W'(CONF_MAX)) begin
      conf = CONF_MAX;
    end else begin
      conf = CONF_W'(prod >>> FRAC_W);
    end
  end

  // Running winner; the first class of a tie stays.
  always_comb begin
    best_base  = (pos_cur == '0) ? '0 : best_q;
    label_base = (pos_cur == '0) ? '0 : label_q;
    found_base = (pos_cur == '0) ? 1'b0 : found_q;
    best_d     = best_base;
    label_d    = label_base;
    found_d    = found_base;
    if (pos_cur >= POS_W'(FIRST_CLASS_POS) && conf > threshold_q && conf > best_base) begin
      best_d  = conf;
      label_d = LABEL_W'(pos_cur - POS_W'(FIRST_CLASS_POS));
      found_d = 1'b1;
    end
  end

  // Anchor walk over the grid and the stride levels.
  always_comb begin
    anchor_end = (pos_cur == POS_W'(VALUES_PER_ANCHOR - 1));
    frame_last = 1'b0;
    pos_d      = pos_cur + POS_W'(1);
    col_d      = col_cur;
    row_d      = row_cur;
    lvl_d      = lvl_cur;
    if (anchor_end) begin
      pos_d = '0;
      col_d = col_cur + COL_W'(1);
      if (col_cur == LVL_COL_LAST[lvl_cur]) begin
        col_d = '0;
        row_d = row_cur + ROW_W'(1);
        if (row_cur == LVL_ROW_LAST[lvl_cur]) begin
          row_d = '0;
          if (lvl_cur == LVL_S32) begin
            lvl_d      = LVL_S8;
            frame_last = 1'b1;
          end else begin
            lvl_d = lvl_cur + LVL_W'(1);
          end
        end
      end
    end
  end

  // Counters and running winner.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      lvl_q   <= LVL_S8;
      best_q  <= '0;
      label_q <= '0;
      found_q <= 1'b0;
      obj_q   <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      col_q   <= col_d;
      row_q   <= row_d;
      lvl_q   <= lvl_d;
      best_q  <= best_d;
      label_q <= label_d;
      found_q <= found_d;
      if (pos_cur == POS_W'(OBJ_POS)) begin
        obj_q <= pred_i.pred_value;
      end
    end
  end

  // Decoded corner store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CORNER_VALUES; i++) begin
        corner_q[i] <= '0;
      end
    end else if (accept && pos_cur < POS_W'(CORNER_VALUES)) begin
      corner_q[pos_cur[2:0]] <= corner_val;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && anchor_end) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word; fields are zero when no class was found.
  always_ff @(posedge clk_i) begin
    if (accept && anchor_end) begin
      result_o.found       <= found_d;
      result_o.last_anchor <= frame_last;
      result_o.corner1_x   <= found_d ? corner_q[0] : '0;
      result_o.corner1_y   <= found_d ? corner_q[1] : '0;
      result_o.corner2_x   <= found_d ? corner_q[2] : '0;
      result_o.corner2_y   <= found_d ? corner_q[3] : '0;
      result_o.corner3_x   <= found_d ? corner_q[4] : '0;
      result_o.corner3_y   <= found_d ? corner_q[5] : '0;
      result_o.corner4_x   <= found_d ? corner_q[6] : '0;
      result_o.corner4_y   <= found_d ? corner_q[7] : '0;
      result_o.class_label <= found_d ? label_d : '0;
      result_o.confidence  <= found_d ? best_d : '0;
    end
  end

  assign result_o.valid = out_valid_q;

endmodule
